/* rtl/core/ocx_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the order crossover unit.
// No dependencies.
package ocx_pkg;

    localparam int OCX_MAX_CITIES = 64;
    localparam int OCX_LABEL_BITS = 16;

    localparam int CITY_W = 16;
    localparam int CUT_W  = 6;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_CUTS = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ERR,
        ST_SEG_RD,
        ST_SEG_LAT,
        ST_SCAN,
        ST_SCAN_END,
        ST_EMIT_RD,
        ST_EMIT_WR
    } ocx_state_t;

endpackage

/* rtl/core/ocx_tour_mem.sv */
`timescale 1ns / 1ps
// Parent tour stores: two synchronous memories, one write port, one read port each.
// Depends on ocx_pkg for parameter defaults.
module ocx_tour_mem import ocx_pkg::*; #(
    parameter int MAX_CITIES = OCX_MAX_CITIES,
    parameter int LABEL_BITS = OCX_LABEL_BITS,
    localparam int AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [LABEL_BITS-1:0] wr_first,
    input  logic [LABEL_BITS-1:0] wr_second,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr_first,
    input  logic [AW-1:0]         rd_addr_second,
    output logic [LABEL_BITS-1:0] rd_first,
    output logic [LABEL_BITS-1:0] rd_second
);

    logic [LABEL_BITS-1:0] first_mem  [MAX_CITIES];
    logic [LABEL_BITS-1:0] second_mem [MAX_CITIES];
    logic [LABEL_BITS-1:0] rd_first_reg;
    logic [LABEL_BITS-1:0] rd_second_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            first_mem[wr_addr]  <= wr_first;
            second_mem[wr_addr] <= wr_second;
        end
        if (rd_en) begin
            rd_first_reg  <= first_mem[rd_addr_first];
            rd_second_reg <= second_mem[rd_addr_second];
        end
    end

    assign rd_first  = rd_first_reg;
    assign rd_second = rd_second_reg;

endmodule

/* rtl/core/order_crossover_permutation_unit.sv */
`timescale 1ns / 1ps
// Order crossover (OX) of two parent tours: load, removal scan, child emission.
// Depends on ocx_pkg and ocx_tour_mem.
//
//  channel | dir | tdata / tuser / tlast
//  s_      | in  | city_first, city_second, cut_start, cut_end / - / last_element
//  m_      | out | child_first_city, child_second_city / status / last_result
//
// Load: one transaction per cycle, written straight into the tour memories until they are full.
// Removal: one memory read per position per segment label.
// Emission: per result, memory read then output register; error result: register only.
// Output register decouples m_tready; input is taken again while the final result waits.
// aresetn is synchronous, active low; it clears control state only.
module order_crossover_permutation_unit import ocx_pkg::*; #(
    parameter int MAX_CITIES = OCX_MAX_CITIES,
    parameter int LABEL_BITS = OCX_LABEL_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // city_first[15:0], city_second[31:16],
                                   // cut_start[37:32], cut_end[43:38], zeros
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // child_first_city[15:0], child_second_city[31:16]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    localparam int AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int CW = $clog2(MAX_CITIES + 1);

    function automatic logic [AW-1:0] onehot_idx(input logic [MAX_CITIES-1:0] v);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_CITIES; i++) begin
            if (v[i]) idx = idx | AW'(i);
        end
        return idx;
    endfunction

    ocx_state_t state_reg, state_next;

    logic [CW-1:0]         len_reg, len_next;
    logic                  ovf_reg, ovf_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [AW-1:0]         lo_reg, lo_next;
    logic [AW-1:0]         hi_reg, hi_next;
    logic [AW-1:0]         k_reg, k_next;
    logic [STAT_W-1:0]     err_reg, err_next;
    logic [LABEL_BITS-1:0] lab1_reg, lab1_next;
    logic [LABEL_BITS-1:0] lab2_reg, lab2_next;
    logic [AW-1:0]         p_reg, p_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [AW-1:0]         chk_pos_reg, chk_pos_next;
    logic                  done1_reg, done1_next;
    logic                  done2_reg, done2_next;
    logic [MAX_CITIES-1:0] marks1_reg, marks1_next;
    logic [MAX_CITIES-1:0] marks2_reg, marks2_next;
    logic [CW-1:0]         seg_addr_reg, seg_addr_next;
    logic [CW-1:0]         r1_reg, r1_next;
    logic [CW-1:0]         r2_reg, r2_next;
    logic [AW-1:0]         nxt1_reg, nxt1_next;
    logic [AW-1:0]         nxt2_reg, nxt2_next;
    logic                  seg_ph_reg, seg_ph_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [31:0]           m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;
    logic [STAT_W-1:0]     m_tuser_reg, m_tuser_next;

    logic                  mem_wr_en;
    logic                  mem_rd_en;
    logic [AW-1:0]         rd_addr_first;
    logic [AW-1:0]         rd_addr_second;
    logic [LABEL_BITS-1:0] rd_first;
    logic [LABEL_BITS-1:0] rd_second;

    logic [CITY_W-1:0]     in_first;
    logic [CITY_W-1:0]     in_second;
    logic [CUT_W-1:0]      in_cut_a;
    logic [CUT_W-1:0]      in_cut_b;
    logic [CUT_W-1:0]      cut_lo;
    logic [CUT_W-1:0]      cut_hi;
    logic                  full;
    logic [CW-1:0]         n_new;
    logic                  cuts_bad;
    logic                  out_free;
    logic                  seg_now;

    logic [MAX_CITIES-1:0] avail1, avail2;
    logic [MAX_CITIES-1:0] iso1, iso2;
    logic [AW-1:0]         nxt1, nxt2;

    assign in_first  = s_tdata[15:0];
    assign in_second = s_tdata[31:16];
    assign in_cut_a  = s_tdata[37:32];
    assign in_cut_b  = s_tdata[43:38];

    assign cut_lo   = (in_cut_b < in_cut_a) ? in_cut_b : in_cut_a;
    assign cut_hi   = (in_cut_b < in_cut_a) ? in_cut_a : in_cut_b;
    assign full     = (len_reg == CW'(MAX_CITIES));
    assign n_new    = full ? len_reg : len_reg + 1'b1;
    assign cuts_bad = (cut_lo == cut_hi) || (7'(cut_hi) >= 7'(n_new));
    assign out_free = !m_tvalid_reg || m_tready;
    assign seg_now  = (seg_addr_reg <= CW'(hi_reg));

    // next unremoved position at or after the running pointer
    assign avail1 = ~marks1_reg & ({MAX_CITIES{1'b1}} << r1_reg);
    assign avail2 = ~marks2_reg & ({MAX_CITIES{1'b1}} << r2_reg);
    assign iso1   = avail1 & (~avail1 + 1'b1);
    assign iso2   = avail2 & (~avail2 + 1'b1);
    assign nxt1   = onehot_idx(iso1);
    assign nxt2   = onehot_idx(iso2);

    ocx_tour_mem #(
        .MAX_CITIES (MAX_CITIES),
        .LABEL_BITS (LABEL_BITS)
    ) u_mem (
        .aclk           (aclk),
        .wr_en          (mem_wr_en),
        .wr_addr        (len_reg[AW-1:0]),
        .wr_first       (LABEL_BITS'(in_first)),
        .wr_second      (LABEL_BITS'(in_second)),
        .rd_en          (mem_rd_en),
        .rd_addr_first  (rd_addr_first),
        .rd_addr_second (rd_addr_second),
        .rd_first       (rd_first),
        .rd_second      (rd_second)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            chk_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            chk_vld_reg  <= chk_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        n_reg        <= n_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        err_reg      <= err_next;
        lab1_reg     <= lab1_next;
        lab2_reg     <= lab2_next;
        p_reg        <= p_next;
        chk_pos_reg  <= chk_pos_next;
        done1_reg    <= done1_next;
        done2_reg    <= done2_next;
        marks1_reg   <= marks1_next;
        marks2_reg   <= marks2_next;
        seg_addr_reg <= seg_addr_next;
        r1_reg       <= r1_next;
        r2_reg       <= r2_next;
        nxt1_reg     <= nxt1_next;
        nxt2_reg     <= nxt2_next;
        seg_ph_reg   <= seg_ph_next;
        cnt_reg      <= cnt_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
        m_tuser_reg  <= m_tuser_next;
    end

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        n_next        = n_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        k_next        = k_reg;
        err_next      = err_reg;
        lab1_next     = lab1_reg;
        lab2_next     = lab2_reg;
        p_next        = p_reg;
        chk_vld_next  = 1'b0;
        chk_pos_next  = p_reg;
        done1_next    = done1_reg;
        done2_next    = done2_reg;
        marks1_next   = marks1_reg;
        marks2_next   = marks2_reg;
        seg_addr_next = seg_addr_reg;
        r1_next       = r1_reg;
        r2_next       = r2_reg;
        nxt1_next     = nxt1_reg;
        nxt2_next     = nxt2_reg;
        seg_ph_next   = seg_ph_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        rd_addr_first  = '0;
        rd_addr_second = '0;
        s_tready       = 1'b0;

        // removal compare, in the cycle after the scan read
        if (chk_vld_reg) begin
            if (!done1_reg && !marks1_reg[chk_pos_reg] && rd_first == lab1_reg) begin
                marks1_next[chk_pos_reg] = 1'b1;
                done1_next = 1'b1;
            end
            if (!done2_reg && !marks2_reg[chk_pos_reg] && rd_second == lab2_reg) begin
                marks2_next[chk_pos_reg] = 1'b1;
                done2_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (!full) begin
                        mem_wr_en = 1'b1;
                        len_next  = len_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        len_next    = '0;
                        ovf_next    = 1'b0;
                        n_next      = n_new;
                        marks1_next = '0;
                        marks2_next = '0;
                        lo_next     = AW'(cut_lo);
                        hi_next     = AW'(cut_hi);
                        k_next      = AW'(cut_lo);
                        priority if (ovf_reg || full) begin
                            err_next   = STATUS_OVERFLOW;
                            state_next = ST_ERR;
                        end else if (cuts_bad) begin
                            err_next   = STATUS_BAD_CUTS;
                            state_next = ST_ERR;
                        end else begin
                            state_next = ST_SEG_RD;
                        end
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = err_reg;
                    state_next    = ST_LOAD;
                end
            end
            ST_SEG_RD: begin
                mem_rd_en      = 1'b1;
                rd_addr_first  = k_reg;
                rd_addr_second = k_reg;
                state_next     = ST_SEG_LAT;
            end
            ST_SEG_LAT: begin
                lab1_next  = rd_second;
                lab2_next  = rd_first;
                p_next     = '0;
                done1_next = 1'b0;
                done2_next = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                mem_rd_en      = 1'b1;
                rd_addr_first  = p_reg;
                rd_addr_second = p_reg;
                chk_vld_next   = 1'b1;
                chk_pos_next   = p_reg;
                if (CW'(p_reg) == n_reg - 1'b1) begin
                    state_next = ST_SCAN_END;
                end else begin
                    p_next = p_reg + 1'b1;
                end
            end
            ST_SCAN_END: begin
                if (k_reg == hi_reg) begin
                    seg_addr_next = CW'(lo_reg);
                    r1_next       = '0;
                    r2_next       = '0;
                    cnt_next      = '0;
                    state_next    = ST_EMIT_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SEG_RD;
                end
            end
            ST_EMIT_RD: begin
                mem_rd_en   = 1'b1;
                seg_ph_next = seg_now;
                if (seg_now) begin
                    rd_addr_first  = seg_addr_reg[AW-1:0];
                    rd_addr_second = seg_addr_reg[AW-1:0];
                end else begin
                    rd_addr_first  = nxt1;
                    rd_addr_second = nxt2;
                    nxt1_next      = nxt1;
                    nxt2_next      = nxt2;
                end
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = STATUS_OK;
                    m_tlast_next  = (cnt_reg + 1'b1 == n_reg);
                    cnt_next      = cnt_reg + 1'b1;
                    if (seg_ph_reg) begin
                        m_tdata_next  = {CITY_W'(rd_first), CITY_W'(rd_second)};
                        seg_addr_next = seg_addr_reg + 1'b1;
                    end else begin
                        m_tdata_next = {CITY_W'(rd_second), CITY_W'(rd_first)};
                        r1_next      = CW'(nxt1_reg) + 1'b1;
                        r2_next      = CW'(nxt2_reg) + 1'b1;
                    end
                    state_next = (cnt_reg + 1'b1 == n_reg) ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_WR) |-> (cnt_reg < n_reg))
        else $error("emit count ran past tour length");

    a_rest_in_tour: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_RD && !seg_now) |->
            (CW'(nxt1) < n_reg && CW'(nxt2) < n_reg))
        else $error("no unremoved position left inside the tour");

    a_marks_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD && state_reg != ST_ERR) |->
            ($countones(marks1_reg) <= int'(k_reg) - int'(lo_reg) + 1 &&
             $countones(marks2_reg) <= int'(k_reg) - int'(lo_reg) + 1))
        else $error("more removals than segment labels");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CW'(p_reg) < n_reg))
        else $error("scan address beyond tour length");

endmodule
